// ----- rtl/assert_macros.svh -----
// assertion macros shared by the button press classifier rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bpc assertion failed");
`define BPC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bpc forbidden condition");
`else
`define BPC_ASSERT(lbl, prop)
`define BPC_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/bpc_pkg.sv -----
// types and constants of the button press classifier
// no dependencies
`default_nettype none

package bpc_pkg;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned TAP_W    = 8;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TAP_W-1:0] TAP_MAX     = 8'd255;
  localparam logic [TAP_W-1:0] DOUBLE_TAPS = 8'd2;

  localparam logic              RST_MULTI_MODE    = 1'b1;
  localparam logic              RST_PRESSED_LEVEL = 1'b0;
  localparam logic [TIME_W-1:0] RST_DEBOUNCE_TIME = 16'd50;
  localparam logic [TIME_W-1:0] RST_SHORT_TIME    = 16'd200;
  localparam logic [TIME_W-1:0] RST_LONG_TIME     = 16'd1000;
  localparam logic [TIME_W-1:0] RST_MAX_HOLD_TIME = 16'd2000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_PRESS  = 3'd1,
    ACT_SHORT  = 3'd2,
    ACT_LONG   = 3'd3,
    ACT_DOUBLE = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULTI_MODE    = 3'd0,
    REG_PRESSED_LEVEL = 3'd1,
    REG_DEBOUNCE_TIME = 3'd2,
    REG_SHORT_TIME    = 3'd3,
    REG_LONG_TIME     = 3'd4,
    REG_MAX_HOLD_TIME = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic              multi_mode;
    logic              pressed_level;
    logic [TIME_W-1:0] debounce_time;
    logic [TIME_W-1:0] short_time;
    logic [TIME_W-1:0] long_time;
    logic [TIME_W-1:0] max_hold_time;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/bpc_in_if.sv -----
// input tick channel of the button press classifier
// depends on bpc_pkg
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;

  logic              valid;
  logic              ready;
  logic              pin_level;
  logic [TIME_W-1:0] elapsed;

  modport source (output valid, output pin_level, output elapsed, input ready);
  modport sink (input valid, input pin_level, input elapsed, output ready);
endinterface

`default_nettype wire

// ----- rtl/bpc_out_if.sv -----
// result channel of the button press classifier
// depends on bpc_pkg
`default_nettype none

interface bpc_out_if;
  import bpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;

  modport source (output valid, output action, input ready);
  modport sink (input valid, input action, output ready);
endinterface

`default_nettype wire

// ----- rtl/bpc_cfg_if.sv -----
// register write channel of the button press classifier
// depends on bpc_pkg
`default_nettype none

interface bpc_cfg_if;
  import bpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/button_press_classifier.sv -----
// Button press classifier: takes one tick beat per clock cycle carrying the
// sampled pin level and the elapsed time, and returns exactly one action beat
// per tick (none, press, short, long or double press). Ticks are taken every
// cycle while results drain; a result passes the tick register and then the
// result register, and a result-side stall can hold it between them. Held
// time, press flag and tap count are updated from the tick register, which
// sets the rate of one tick per cycle while results drain. Registers reset
// to multi mode, pressed level 0, debounce 50, short 200, long 1000 and hold
// ceiling 2000, and should be written only while no tick is in flight.
// depends on bpc_pkg, the channel interfaces, bpc_cfg_regs and bpc_core
`default_nettype none

module button_press_classifier (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpc_cfg_if.sink   cfg_i,
  bpc_in_if.sink    in_i,
  bpc_out_if.source out_o
);
  import bpc_pkg::*;

  cfg_t cfg_regs;

  bpc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .cfg_regs_o (cfg_regs)
  );

  bpc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_regs_i (cfg_regs),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ----- rtl/bpc_cfg_regs.sv -----
// configuration registers of the button press classifier
// depends on bpc_pkg and bpc_cfg_if
`default_nettype none

module bpc_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  bpc_cfg_if.sink           cfg_i,
  output bpc_pkg::cfg_t     cfg_regs_o
);
  import bpc_pkg::*;

  cfg_t     regs_q;
  cfg_t     regs_d;
  reg_idx_e idx;

  assign cfg_i.ready = 1'b1;
  assign idx         = reg_idx_e'(cfg_i.index);
  assign cfg_regs_o  = regs_q;

  always_comb begin
    regs_d = regs_q;
    case (idx)
      REG_MULTI_MODE:    regs_d.multi_mode    = cfg_i.data[0];
      REG_PRESSED_LEVEL: regs_d.pressed_level = cfg_i.data[0];
      REG_DEBOUNCE_TIME: regs_d.debounce_time = cfg_i.data[TIME_W-1:0];
      REG_SHORT_TIME:    regs_d.short_time    = cfg_i.data[TIME_W-1:0];
      REG_LONG_TIME:     regs_d.long_time     = cfg_i.data[TIME_W-1:0];
      REG_MAX_HOLD_TIME: regs_d.max_hold_time = cfg_i.data[TIME_W-1:0];
      default:           regs_d = regs_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.multi_mode    <= RST_MULTI_MODE;
      regs_q.pressed_level <= RST_PRESSED_LEVEL;
      regs_q.debounce_time <= RST_DEBOUNCE_TIME;
      regs_q.short_time    <= RST_SHORT_TIME;
      regs_q.long_time     <= RST_LONG_TIME;
      regs_q.max_hold_time <= RST_MAX_HOLD_TIME;
    end else if (cfg_i.valid && cfg_i.ready) begin
      regs_q <= regs_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bpc_core.sv -----
// tick register, press state update and result register of the classifier
// depends on bpc_pkg, bpc_in_if, bpc_out_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bpc_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bpc_pkg::cfg_t cfg_regs_i,
  bpc_in_if.sink             in_i,
  bpc_out_if.source          out_o
);
  import bpc_pkg::*;

  // input stage
  logic              in_vld_q;
  logic              pin_q;
  logic [TIME_W-1:0] elapsed_q;

  // result stage
  logic              out_vld_q;
  action_e           action_q;

  // press state
  logic              press_q;
  logic              press_d;
  logic [TIME_W-1:0] held_q;
  logic [TIME_W-1:0] held_d;
  logic [TAP_W-1:0]  tap_q;
  logic [TAP_W-1:0]  tap_d;
  action_e           action_d;

  logic              advance;
  logic              pressed;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] held_sum;

  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = out_vld_q;
  assign out_o.action = action_q;

  assign pressed  = (pin_q == cfg_regs_i.pressed_level);
  assign sum      = {1'b0, held_q} + {1'b0, elapsed_q};
  assign held_sum = (sum >= {1'b0, cfg_regs_i.max_hold_time}) ?
                    cfg_regs_i.max_hold_time : sum[TIME_W-1:0];

  always_comb begin
    held_d   = held_q;
    press_d  = press_q;
    tap_d    = tap_q;
    action_d = ACT_NONE;
    if (pressed) begin
      held_d = held_sum;
      if (held_sum >= cfg_regs_i.debounce_time && !press_q) begin
        action_d = ACT_PRESS;
        press_d  = 1'b1;
        if (cfg_regs_i.multi_mode && tap_q != TAP_MAX) begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
    end else begin
      if (cfg_regs_i.multi_mode) begin
        if (held_q >= cfg_regs_i.long_time) begin
          action_d = ACT_LONG;
          tap_d    = '0;
        end else if (held_q >= cfg_regs_i.short_time) begin
          action_d = ACT_SHORT;
          tap_d    = '0;
        end else if (tap_q == DOUBLE_TAPS) begin
          action_d = ACT_DOUBLE;
          tap_d    = '0;
        end
      end else if (held_q >= cfg_regs_i.short_time) begin
        action_d = ACT_SHORT;
      end
      held_d  = '0;
      press_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      held_q    <= '0;
      press_q   <= 1'b0;
      tap_q     <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        held_q    <= held_d;
        press_q   <= press_d;
        tap_q     <= tap_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pin_q     <= in_i.pin_level;
      elapsed_q <= in_i.elapsed;
    end
    if (advance) begin
      action_q <= action_d;
    end
  end

  `BPC_ASSERT(a_release_clears, (advance && !pressed) |=> (held_q == '0 && !press_q))
  `BPC_ASSERT(a_press_flagged, (out_vld_q && action_q == ACT_PRESS) |-> press_q)
  `BPC_ASSERT(a_tap_only_on_beat, !$past(advance) |-> $stable(tap_q))
  `BPC_ASSERT_NEVER(a_two_taps_on_press, advance && pressed && (tap_d - tap_q) > TAP_W'(1))

endmodule

`default_nettype wire

// ----- tb/sv/button_press_classifier_tb.sv -----
// self-checking testbench of button_press_classifier: directed and random tick beats
// are checked against an in-bench predictor of press, short, long and double press
// depends on bpc_pkg, the bpc channel interfaces and button_press_classifier
`default_nettype none

module button_press_classifier_tb;
  import bpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int unsigned MAX_IDLE = 17;

  typedef struct {
    logic              pin_level;
    logic [TIME_W-1:0] elapsed;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpc_cfg_if cfg_if ();
  bpc_in_if  tick_if ();
  bpc_out_if act_if ();

  button_press_classifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (tick_if),
    .out_o  (act_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tick_t       pending_ticks[$];
  action_e     expected_actions[$];
  int unsigned ticks_queued;
  int unsigned ticks_accepted;
  int unsigned mismatches;
  logic        stim_level;

  logic        tick_fire;
  logic        act_fire;
  logic        cfg_fire;
  int unsigned tick_hold;
  int unsigned act_stall;
  logic        tick_calm;
  logic        act_calm;

  // predictor state and register mirror
  cfg_t              model_cfg;
  logic [TIME_W-1:0] held_time;
  logic              press_seen;
  logic [TAP_W-1:0]  taps;

  function automatic int unsigned idle_cycles(logic calm);
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic action_e classify_tick(logic pin, logic [TIME_W-1:0] el);
    logic [TIME_W:0] sum;
    action_e         act;
    act = ACT_NONE;
    if (pin == model_cfg.pressed_level) begin
      sum = {1'b0, held_time} + {1'b0, el};
      if (sum >= {1'b0, model_cfg.max_hold_time}) sum = {1'b0, model_cfg.max_hold_time};
      held_time = sum[TIME_W-1:0];
      if (held_time >= model_cfg.debounce_time && !press_seen) begin
        act = ACT_PRESS;
        press_seen = 1'b1;
        if (model_cfg.multi_mode && taps != TAP_MAX) taps = taps + TAP_W'(1);
      end
    end else begin
      if (model_cfg.multi_mode) begin
        if (held_time >= model_cfg.long_time) begin
          act = ACT_LONG;
          taps = '0;
        end else if (held_time >= model_cfg.short_time) begin
          act = ACT_SHORT;
          taps = '0;
        end else if (taps == DOUBLE_TAPS) begin
          act = ACT_DOUBLE;
          taps = '0;
        end
      end else if (held_time >= model_cfg.short_time) begin
        act = ACT_SHORT;
      end
      held_time = '0;
      press_seen = 1'b0;
    end
    return act;
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) $display("tb: %s, expected %0d got %0d", what, want, got);
  endtask

  // monitor: register mirror, result check and prediction
  always @(posedge clk_i) begin
    tick_fire <= rst_ni && tick_if.valid && tick_if.ready;
    act_fire  <= rst_ni && act_if.valid && act_if.ready;
    cfg_fire  <= rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_MULTI_MODE:    model_cfg.multi_mode    = cfg_if.data[0];
          REG_PRESSED_LEVEL: model_cfg.pressed_level = cfg_if.data[0];
          REG_DEBOUNCE_TIME: model_cfg.debounce_time = cfg_if.data;
          REG_SHORT_TIME:    model_cfg.short_time    = cfg_if.data;
          REG_LONG_TIME:     model_cfg.long_time     = cfg_if.data;
          REG_MAX_HOLD_TIME: model_cfg.max_hold_time = cfg_if.data;
          default: ;
        endcase
      end
      if (act_if.valid && act_if.ready) begin
        if (expected_actions.size() == 0) begin
          note_mismatch("result beat with no tick pending", -1, int'(act_if.action));
        end else if (act_if.action !== expected_actions[0]) begin
          note_mismatch("action mismatch", int'(expected_actions[0]), int'(act_if.action));
          void'(expected_actions.pop_front());
        end else begin
          void'(expected_actions.pop_front());
        end
      end
      if (tick_if.valid && tick_if.ready) begin
        expected_actions.push_back(classify_tick(tick_if.pin_level, tick_if.elapsed));
        ticks_accepted++;
      end
    end
  end

  // tick driver
  always @(negedge clk_i) begin
    if (rst_ni && (!tick_if.valid || tick_fire)) begin
      if (tick_hold != 0) begin
        tick_if.valid <= 1'b0;
        tick_hold <= tick_hold - 1;
      end else if (pending_ticks.size() != 0) begin
        tick_if.valid     <= 1'b1;
        tick_if.pin_level <= pending_ticks[0].pin_level;
        tick_if.elapsed   <= pending_ticks[0].elapsed;
        void'(pending_ticks.pop_front());
        tick_hold <= idle_cycles(tick_calm);
        if ($urandom_range(0, 39) == 0) tick_calm <= !tick_calm;
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls
  always @(negedge clk_i) begin : result_sink
    int unsigned stall;
    if (rst_ni) begin
      stall = act_stall;
      if (act_fire) begin
        stall = idle_cycles(act_calm);
        if ($urandom_range(0, 39) == 0) act_calm <= !act_calm;
      end
      if (stall != 0) begin
        act_if.ready <= 1'b0;
        act_stall <= stall - 1;
      end else begin
        act_if.ready <= 1'b1;
      end
    end
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_PRESSED_LEVEL) stim_level = val[0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (ticks_accepted != ticks_queued || expected_actions.size() != 0);
  endtask

  task automatic add_tick(logic pin, logic [TIME_W-1:0] el);
    tick_t t;
    t.pin_level = pin;
    t.elapsed   = el;
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  task automatic hold_tick(logic [TIME_W-1:0] el);
    add_tick(stim_level, el);
  endtask

  task automatic lift_tick(logic [TIME_W-1:0] el);
    add_tick(!stim_level, el);
  endtask

  function automatic logic [TIME_W-1:0] pick_elapsed(int unsigned span);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(0, span));
    endcase
  endfunction

  task automatic add_gesture(int unsigned span);
    int unsigned holds;
    int unsigned lifts;
    holds = $urandom_range(1, 6);
    lifts = $urandom_range(1, 2);
    repeat (holds) hold_tick(pick_elapsed(span));
    repeat (lifts) lift_tick(pick_elapsed(span));
  endtask

  task automatic run_gestures(int unsigned count, int unsigned span);
    int unsigned start;
    start = ticks_queued;
    while (ticks_queued - start < count) begin
      if ($urandom_range(0, 9) == 0) add_tick(1'($urandom_range(0, 1)), pick_elapsed(span));
      else add_gesture(span);
    end
  endtask

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    tick_if.valid = 1'b0;
    tick_if.pin_level = 1'b0;
    tick_if.elapsed = '0;
    act_if.ready = 1'b0;
    tick_fire = 1'b0;
    act_fire = 1'b0;
    cfg_fire = 1'b0;
    tick_hold = 0;
    act_stall = 0;
    tick_calm = 1'b0;
    act_calm = 1'b1;
    ticks_queued = 0;
    ticks_accepted = 0;
    mismatches = 0;
    stim_level = RST_PRESSED_LEVEL;
    model_cfg.multi_mode    = RST_MULTI_MODE;
    model_cfg.pressed_level = RST_PRESSED_LEVEL;
    model_cfg.debounce_time = RST_DEBOUNCE_TIME;
    model_cfg.short_time    = RST_SHORT_TIME;
    model_cfg.long_time     = RST_LONG_TIME;
    model_cfg.max_hold_time = RST_MAX_HOLD_TIME;
    held_time = '0;
    press_seen = 1'b0;
    taps = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset thresholds: saturation without wrap, debounce edge, double, short, long
    lift_tick(16'd0);
    hold_tick(16'hFFFF);
    hold_tick(16'hFFFF);
    lift_tick(16'hFFFF);
    hold_tick(16'd30);
    hold_tick(16'd20);
    lift_tick(16'd5);
    hold_tick(16'd60);
    lift_tick(16'd0);
    hold_tick(16'd200);
    lift_tick(16'd1);
    hold_tick(16'd999);
    lift_tick(16'd0);
    hold_tick(16'd1000);
    lift_tick(16'd0);
    wait_idle();

    // single mode, inverted level, then a mode switch in the middle of a hold
    set_reg(REG_MULTI_MODE, 16'd0);
    set_reg(REG_PRESSED_LEVEL, 16'd1);
    hold_tick(16'd1100);
    lift_tick(16'd0);
    hold_tick(16'd10);
    lift_tick(16'd0);
    hold_tick(16'd1200);
    wait_idle();
    set_reg(REG_MULTI_MODE, 16'd1);
    lift_tick(16'd0);
    wait_idle();

    // zero debounce, long threshold below short
    set_reg(REG_DEBOUNCE_TIME, 16'd0);
    set_reg(REG_LONG_TIME, 16'd100);
    set_reg(REG_SHORT_TIME, 16'd300);
    hold_tick(16'd0);
    lift_tick(16'd0);
    hold_tick(16'd150);
    lift_tick(16'd0);
    wait_idle();

    set_reg(REG_DEBOUNCE_TIME, RST_DEBOUNCE_TIME);
    set_reg(REG_SHORT_TIME, RST_SHORT_TIME);
    set_reg(REG_LONG_TIME, RST_LONG_TIME);
    run_gestures(10, 400);
    wait_idle();

    set_reg(REG_MULTI_MODE, 16'd0);
    set_reg(REG_PRESSED_LEVEL, 16'd1);
    set_reg(REG_DEBOUNCE_TIME, CFG_DATA_W'($urandom_range(0, 100)));
    set_reg(REG_SHORT_TIME, CFG_DATA_W'($urandom_range(50, 400)));
    set_reg(REG_LONG_TIME, CFG_DATA_W'($urandom_range(300, 1200)));
    set_reg(REG_MAX_HOLD_TIME, CFG_DATA_W'($urandom_range(200, 2500)));
    run_gestures(10, 300);
    wait_idle();

    // brief taps only, enough to drive the tap count into saturation
    set_reg(REG_MULTI_MODE, 16'd1);
    set_reg(REG_PRESSED_LEVEL, CFG_DATA_W'($urandom));
    set_reg(REG_DEBOUNCE_TIME, 16'd0);
    set_reg(REG_SHORT_TIME, 16'd0);
    hold_tick(16'd1);
    lift_tick(16'd0);
    wait_idle();
    set_reg(REG_SHORT_TIME, 16'hFFFF);
    set_reg(REG_LONG_TIME, 16'hFFFF);
    set_reg(REG_MAX_HOLD_TIME, 16'd40000);
    // two taps, then a single-mode release keeps the count at two
    hold_tick(16'd1);
    lift_tick(16'd1);
    hold_tick(16'd1);
    wait_idle();
    set_reg(REG_MULTI_MODE, 16'd0);
    lift_tick(16'd1);
    wait_idle();
    set_reg(REG_MULTI_MODE, 16'd1);
    repeat (254) begin
      hold_tick(pick_elapsed(2000));
      lift_tick(pick_elapsed(2000));
    end
    wait_idle();

    set_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
    set_reg(REG_SHORT_TIME, 16'd0);
    set_reg(REG_MAX_HOLD_TIME, 16'hFFFF);
    run_gestures(8, 40000);
    wait_idle();

    set_reg(REG_MAX_HOLD_TIME, 16'd0);
    set_reg(REG_DEBOUNCE_TIME, 16'd0);
    set_reg(REG_SHORT_TIME, 16'd5);
    set_reg(REG_LONG_TIME, 16'd0);
    set_reg(REG_MULTI_MODE, CFG_DATA_W'($urandom));
    run_gestures(8, 10);

    repeat (3) begin
      wait_idle();
      set_reg(IDX_SPARE_LO, CFG_DATA_W'($urandom));
      set_reg(IDX_SPARE_HI, CFG_DATA_W'($urandom));
      set_reg(REG_MULTI_MODE, CFG_DATA_W'($urandom));
      set_reg(REG_PRESSED_LEVEL, CFG_DATA_W'($urandom));
      set_reg(REG_DEBOUNCE_TIME, CFG_DATA_W'($urandom_range(0, 300)));
      set_reg(REG_SHORT_TIME, CFG_DATA_W'($urandom_range(0, 600)));
      set_reg(REG_LONG_TIME, CFG_DATA_W'($urandom_range(0, 800)));
      set_reg(REG_MAX_HOLD_TIME, CFG_DATA_W'($urandom_range(0, 1500)));
      run_gestures(5, 200);
    end
    wait_idle();
    repeat (8) @(negedge clk_i);

    if (mismatches == 0 && expected_actions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
